/* design/assert_macros.svh */
// Assertion helpers for the design files; deq_ctrl includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* design/deq_pkg.sv */
package deq_pkg;

  // Default number of entries in the ring store.
  localparam int DEPTH_DEF = 64;

  // Width of one stored element.
  localparam int DATA_W = 32;

  // Request codes.
  typedef enum logic [2:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_DUMP       = 3'd2,
    KIND_POP_FRONT  = 3'd3,
    KIND_POP_BACK   = 3'd4
  } kind_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DUMP
  } state_t;

  // Memory access strobes from the controller to the store.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_cmd_t;

endpackage

/* design/double_ended_queue.sv */
// Channel   Handshake            Payload
// request   req_valid/req_ready  kind, value
// response  rsp_valid/rsp_ready  status, element, last
//
// Push and pop latch the request while idle, then write or update once the output is free.
// Dump fetches from the single read port of the ring store and, after fetching the front
// element, streams one element per cycle while the response register is free.
// A response register sits at the output, so a new request is taken while a result waits.
// A stalled response holds the controller in place; no state is lost.
// Synchronous reset empties the queue; the store contents are left as they are.
module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  logic [2:0]                        kind,
  input  logic signed [deq_pkg::DATA_W-1:0] value,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output logic [1:0]                        status,
  output logic signed [deq_pkg::DATA_W-1:0] element,
  output logic                              last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  deq_pkg::mem_cmd_t          cmd;
  logic [AW-1:0]              wr_addr, rd_addr;
  logic [deq_pkg::DATA_W-1:0] wr_data, rd_data;
  logic                       out_free, res_load, res_last;
  deq_pkg::status_t           res_status;
  logic [deq_pkg::DATA_W-1:0] res_element;

  assign out_free = !rsp_valid || rsp_ready;

  deq_ctrl #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .CW   (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .kind       (kind),
    .value      (value),
    .out_free   (out_free),
    .res_load   (res_load),
    .res_status (res_status),
    .res_element(res_element),
    .res_last   (res_last),
    .cmd        (cmd),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  deq_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk    (clk),
    .cmd    (cmd),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Response register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Response payload.
  always_ff @(posedge clk) begin
    if (res_load) begin
      status  <= res_status;
      element <= res_element;
      last    <= res_last;
    end
  end

endmodule

/* design/deq_store.sv */
module deq_store #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  deq_pkg::mem_cmd_t           cmd,
  input  logic [AW-1:0]               wr_addr,
  input  logic [deq_pkg::DATA_W-1:0]  wr_data,
  input  logic [AW-1:0]               rd_addr,
  output logic [deq_pkg::DATA_W-1:0]  rd_data
);

  logic [deq_pkg::DATA_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/deq_ctrl.sv */
`include "assert_macros.svh"

module deq_ctrl #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  logic [2:0]                        kind,
  input  logic signed [deq_pkg::DATA_W-1:0] value,
  input  logic                              out_free,
  output logic                              res_load,
  output deq_pkg::status_t                  res_status,
  output logic [deq_pkg::DATA_W-1:0]        res_element,
  output logic                              res_last,
  output deq_pkg::mem_cmd_t                 cmd,
  output logic [AW-1:0]                     wr_addr,
  output logic [deq_pkg::DATA_W-1:0]        wr_data,
  output logic [AW-1:0]                     rd_addr,
  input  logic [deq_pkg::DATA_W-1:0]        rd_data
);

  localparam int SW = AW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);

  deq_pkg::state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] front, front_next;
  logic [AW-1:0] idx, idx_next;
  logic [2:0] kind_q;
  logic [deq_pkg::DATA_W-1:0] value_q;

  logic [CW-1:0] rd_off;
  logic [SW-1:0] rd_sum, back_sum;
  logic [AW-1:0] back_pos, front_dec;
  logic          dump_last;

  // Ring arithmetic: the sums stay below twice the depth, so one subtract wraps them.
  always_comb begin
    rd_sum    = SW'(front) + SW'(rd_off);
    rd_addr   = (rd_sum >= DEPTH_S) ? AW'(rd_sum - DEPTH_S) : AW'(rd_sum);
    back_sum  = SW'(front) + SW'(count);
    back_pos  = (back_sum >= DEPTH_S) ? AW'(back_sum - DEPTH_S) : AW'(back_sum);
    front_dec = (front == '0) ? LAST_POS : front - 1'b1;
    dump_last = (CW'(idx) + 1'b1) == count;
  end

  // State, pointers and the latched transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= deq_pkg::ST_IDLE;
      count <= '0;
      front <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      front <= front_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (req_valid && req_ready) begin
      kind_q  <= kind;
      value_q <= value;
    end
  end

  // Next state, memory commands and result generation.
  always_comb begin
    state_next  = state;
    count_next  = count;
    front_next  = front;
    idx_next    = idx;
    req_ready   = 1'b0;
    res_load    = 1'b0;
    res_status  = deq_pkg::STATUS_OK;
    res_element = '0;
    res_last    = 1'b1;
    cmd         = '0;
    wr_addr     = back_pos;
    wr_data     = value_q;
    rd_off      = '0;

    unique case (state)
      deq_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          state_next = deq_pkg::ST_EXEC;
        end
      end

      deq_pkg::ST_EXEC: begin
        unique case (kind_q)
          deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_BACK: begin
            if (out_free) begin
              res_load   = 1'b1;
              state_next = deq_pkg::ST_IDLE;
              if (count == DEPTH_C) begin
                res_status = deq_pkg::STATUS_FULL;
              end else begin
                cmd.wr_en  = 1'b1;
                count_next = count + 1'b1;
                if (kind_q == deq_pkg::KIND_PUSH_FRONT) begin
                  wr_addr    = front_dec;
                  front_next = front_dec;
                end
              end
            end
          end

          deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_POP_BACK: begin
            if (out_free) begin
              res_load   = 1'b1;
              state_next = deq_pkg::ST_IDLE;
              if (count == '0) begin
                res_status = deq_pkg::STATUS_EMPTY;
              end else begin
                count_next = count - 1'b1;
                if (kind_q == deq_pkg::KIND_POP_FRONT) begin
                  front_next = (front == LAST_POS) ? '0 : front + 1'b1;
                end
              end
            end
          end

          deq_pkg::KIND_DUMP: begin
            if (count == '0) begin
              if (out_free) begin
                res_load   = 1'b1;
                res_status = deq_pkg::STATUS_EMPTY;
                state_next = deq_pkg::ST_IDLE;
              end
            end else begin
              // Fetch the front element; it arrives next cycle.
              cmd.rd_en  = 1'b1;
              idx_next   = '0;
              state_next = deq_pkg::ST_DUMP;
            end
          end

          default: begin
            // Unused codes produce no result.
            state_next = deq_pkg::ST_IDLE;
          end
        endcase
      end

      deq_pkg::ST_DUMP: begin
        // Emit the fetched element and, unless it is the last, fetch the next one in the same cycle.
        if (out_free) begin
          res_load    = 1'b1;
          res_element = rd_data;
          res_last    = dump_last;
          if (dump_last) begin
            state_next = deq_pkg::ST_IDLE;
          end else begin
            cmd.rd_en = 1'b1;
            rd_off    = CW'(idx) + 1'b1;
            idx_next  = idx + 1'b1;
          end
        end
      end

      default: begin
        state_next = deq_pkg::ST_IDLE;
      end
    endcase
  end

  `ASSERT_IMPLIES(a_count_bound, clk, rst, 1'b1, count <= DEPTH_C)
  `ASSERT_IMPLIES(a_load_needs_slot, clk, rst, res_load, out_free)
  `ASSERT_IMPLIES(a_no_write_in_dump, clk, rst, state == deq_pkg::ST_DUMP, !cmd.wr_en)
  `ASSERT_NEXT(a_push_grows, clk, rst, cmd.wr_en, count == CW'($past(count) + 1'b1))
  `ASSERT_NEXT(a_dump_keeps_state, clk, rst, state == deq_pkg::ST_DUMP, $stable(count) && $stable(front))

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam int RING_DEPTH = deq_pkg::DEPTH_DEF;
  localparam int RANDOM_ITEMS = 450;
  localparam int HOLD_CYCLES = 200;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 100;

  // Codes the block must ignore.
  localparam logic [2:0] KIND_RESERVED_FIRST = 3'd5;
  localparam logic [2:0] KIND_RESERVED_MID = 3'd6;
  localparam logic [2:0] KIND_RESERVED_LAST = 3'd7;

  // Mirror of the deque: predicts every reply and checks the replies that come back.
  class deque_scoreboard;
    typedef struct {
      deq_pkg::status_t status;
      logic signed [deq_pkg::DATA_W-1:0] element;
      logic last;
    } reply_t;

    logic signed [deq_pkg::DATA_W-1:0] ring[RING_DEPTH];
    int head;
    int held;
    reply_t pending[$];
    int errors;
    int n_requests;
    int n_ignored;
    int n_results;
    int n_refused;
    int n_empty;
    int n_dumped;

    function new();
      head = 0;
      held = 0;
      errors = 0;
      n_requests = 0;
      n_ignored = 0;
      n_results = 0;
      n_refused = 0;
      n_empty = 0;
      n_dumped = 0;
    endfunction

    function void add_reply(deq_pkg::status_t st, logic signed [deq_pkg::DATA_W-1:0] el,
                            logic lst);
      reply_t r;
      r.status = st;
      r.element = el;
      r.last = lst;
      pending.push_back(r);
    endfunction

    // Apply one accepted request to the mirror and queue the replies it causes.
    function void note_request(logic [2:0] k, logic signed [deq_pkg::DATA_W-1:0] v);
      if (k >= KIND_RESERVED_FIRST) begin
        n_ignored++;
        return;
      end
      n_requests++;
      case (k)
        deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_BACK: begin
          if (held >= RING_DEPTH) begin
            n_refused++;
            add_reply(deq_pkg::STATUS_FULL, '0, 1'b1);
          end else begin
            if (k == deq_pkg::KIND_PUSH_FRONT) begin
              head = (head + RING_DEPTH - 1) % RING_DEPTH;
              ring[head] = v;
            end else begin
              ring[(head + held) % RING_DEPTH] = v;
            end
            held++;
            add_reply(deq_pkg::STATUS_OK, '0, 1'b1);
          end
        end
        deq_pkg::KIND_DUMP: begin
          if (held == 0) begin
            n_empty++;
            add_reply(deq_pkg::STATUS_EMPTY, '0, 1'b1);
          end else begin
            for (int i = 0; i < held; i++)
              add_reply(deq_pkg::STATUS_OK, ring[(head + i) % RING_DEPTH], i == held - 1);
            n_dumped += held;
          end
        end
        default: begin
          // Both pops: the popped value is dropped.
          if (held == 0) begin
            n_empty++;
            add_reply(deq_pkg::STATUS_EMPTY, '0, 1'b1);
          end else begin
            if (k == deq_pkg::KIND_POP_FRONT)
              head = (head + 1) % RING_DEPTH;
            held--;
            add_reply(deq_pkg::STATUS_OK, '0, 1'b1);
          end
        end
      endcase
    endfunction

    // Compare one accepted reply with the oldest prediction.
    function void check_response(logic [1:0] st, logic signed [deq_pkg::DATA_W-1:0] el,
                                 logic lst);
      reply_t want;
      n_results++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, status %0d element %0d last %0d",
                 $time, st, el, lst);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (st !== want.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, want.status, st);
        errors++;
      end
      if (el !== want.element) begin
        $display("%0t: element mismatch, expected %0d, actual %0d", $time, want.element, el);
        errors++;
      end
      if (lst !== want.last) begin
        $display("%0t: last mismatch, expected %0d, actual %0d", $time, want.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  logic [2:0] kind;
  logic signed [deq_pkg::DATA_W-1:0] value;
  logic rsp_valid;
  logic rsp_ready;
  logic [1:0] status;
  logic signed [deq_pkg::DATA_W-1:0] element;
  logic last;

  deque_scoreboard sb;
  int tx_idle_pct;
  int rx_idle_pct;
  int holds_asked;
  int holds_taken;
  int hold_left;
  int quiet_cycles;
  int item_goal;

  double_ended_queue i_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .kind(kind),
    .value(value),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .status(status),
    .element(element),
    .last(last)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Both channels are observed at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready)
        sb.note_request(kind, value);
      if (rsp_valid && rsp_ready)
        sb.check_response(status, element, last);
    end
  end

  // Watchdog: too long without any transaction means the block has hung.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: random back-pressure, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (holds_taken != holds_asked) begin
      hold_left = HOLD_CYCLES;
      holds_taken++;
    end
    if (hold_left != 0) begin
      rsp_ready = 1'b0;
      hold_left--;
    end else begin
      rsp_ready = ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  function automatic logic [deq_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0: return {1'b1, {(deq_pkg::DATA_W-1){1'b0}}};
      1: return {1'b0, {(deq_pkg::DATA_W-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // True while the current phase still has items left to send.
  function automatic bit budget_left();
    return (sb.n_requests + sb.n_ignored) < item_goal;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input logic [2:0] k, input logic [deq_pkg::DATA_W-1:0] v);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_valid = 1'b0;
      kind = 3'($urandom);
      value = $urandom;
      @(negedge clk);
    end
    req_valid = 1'b1;
    kind = k;
    value = v;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted reply has been seen.
  task automatic wait_drained();
    req_valid = 1'b0;
    while (sb.pending.size() != 0)
      @(negedge clk);
  endtask

  task automatic send_push();
    send_request($urandom_range(0, 1) ? deq_pkg::KIND_PUSH_BACK : deq_pkg::KIND_PUSH_FRONT,
                 pick_value());
  endtask

  task automatic send_pop();
    send_request($urandom_range(0, 1) ? deq_pkg::KIND_POP_BACK : deq_pkg::KIND_POP_FRONT,
                 pick_value());
  endtask

  task automatic send_reserved();
    send_request(3'($urandom_range(KIND_RESERVED_FIRST, KIND_RESERVED_LAST)), pick_value());
  endtask

  // Push until full with a little noise, knock on the full store, then dump it.
  task automatic fill_up();
    int r;
    while (sb.held < RING_DEPTH && budget_left()) begin
      r = $urandom_range(0, 99);
      if (r < 6)
        send_pop();
      else if (r < 9)
        send_request(deq_pkg::KIND_DUMP, pick_value());
      else if (r < 11)
        send_reserved();
      else
        send_push();
    end
    repeat ($urandom_range(1, 3)) send_push();
    send_request(deq_pkg::KIND_DUMP, pick_value());
  endtask

  // Pop until empty with a little noise, then pop the empty store and sometimes dump it.
  task automatic drain_out();
    int r;
    while (sb.held > 0 && budget_left()) begin
      r = $urandom_range(0, 99);
      if (r < 8)
        send_push();
      else if (r < 10)
        send_reserved();
      else
        send_pop();
    end
    repeat ($urandom_range(1, 2)) send_pop();
    if ($urandom_range(0, 1))
      send_request(deq_pkg::KIND_DUMP, pick_value());
  endtask

  task automatic send_mixed(input int n);
    int r;
    repeat (n) begin
      if (budget_left()) begin
        r = $urandom_range(0, 99);
        if (r < 8)
          send_reserved();
        else if (r < 18)
          send_request(deq_pkg::KIND_DUMP, pick_value());
        else if (r < 59)
          send_push();
        else
          send_pop();
      end
    end
  endtask

  initial begin
    int r;
    sb = new();
    rst = 1'b1;
    req_valid = 1'b0;
    kind = '0;
    value = '0;
    item_goal = 0;
    tx_idle_pct = 34;
    rx_idle_pct = 65;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty-store answers, ignored codes, extreme values, both ends.
    send_request(deq_pkg::KIND_POP_FRONT, '0);
    send_request(deq_pkg::KIND_POP_BACK, '1);
    send_request(deq_pkg::KIND_DUMP, '0);
    send_request(KIND_RESERVED_FIRST, 32'h1234_5678);
    send_request(KIND_RESERVED_MID, '1);
    send_request(KIND_RESERVED_LAST, '0);
    send_request(deq_pkg::KIND_PUSH_FRONT, 32'h8000_0000);
    send_request(deq_pkg::KIND_PUSH_BACK, 32'h7FFF_FFFF);
    send_request(deq_pkg::KIND_PUSH_FRONT, '0);
    send_request(deq_pkg::KIND_PUSH_BACK, '1);
    send_request(deq_pkg::KIND_PUSH_FRONT, 32'h5555_5555);
    send_request(deq_pkg::KIND_PUSH_BACK, 32'hAAAA_AAAA);
    send_request(deq_pkg::KIND_DUMP, '1);
    send_request(deq_pkg::KIND_POP_FRONT, '0);
    send_request(deq_pkg::KIND_POP_BACK, '0);
    send_request(deq_pkg::KIND_DUMP, '0);
    send_request(deq_pkg::KIND_POP_BACK, '0);
    send_request(deq_pkg::KIND_POP_FRONT, '0);
    send_request(deq_pkg::KIND_POP_FRONT, '0);
    send_request(deq_pkg::KIND_POP_BACK, '0);
    send_request(deq_pkg::KIND_POP_FRONT, '0);
    send_request(deq_pkg::KIND_DUMP, '0);
    wait_drained();

    // Random part in three phases of different idle rates; the last opens with a long receiver hold-off.
    item_goal = sb.n_requests + sb.n_ignored;
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 65 : 0;
      rx_idle_pct = (ph == 0) ? 65 : (ph == 1) ? 34 : 0;
      item_goal += RANDOM_ITEMS / 3;
      @(negedge clk);
      if (ph == 2) begin
        holds_asked++;
        fill_up();
      end
      while (budget_left()) begin
        r = $urandom_range(0, 99);
        if (r < 40)
          fill_up();
        else if (r < 70)
          drain_out();
        else
          send_mixed($urandom_range(8, 30));
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Covered %0d requests and %0d ignored codes, checked %0d results.",
             sb.n_requests, sb.n_ignored, sb.n_results);
    $display("Refused pushes %0d, empty answers %0d, dumped elements %0d.",
             sb.n_refused, sb.n_empty, sb.n_dumped);
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/deq_pkg.sv
design/deq_store.sv
design/deq_ctrl.sv
design/double_ended_queue.sv
sim/tb.sv
